// File: hw/rtl/frd_pkg.sv
package frd_pkg;

	localparam int GUARD = 3;
	localparam int KBITS = 26;
	localparam int DW = 40;
	localparam int SPLIT = 16;
	localparam int GINV_W = 27;
	localparam logic signed [63:0] PI60 = 64'sh3243F6A8885A308D;

	typedef struct packed {
		logic signed [33:0] hd;
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] qx;
		logic signed [31:0] qy;
		logic nz;
		logic neg;
	} pose_sb_t;

	typedef struct packed {
		logic [31:0] rx;
		logic [31:0] ry;
		logic [31:0] hd;
		logic far;
	} dist_sb_t;

	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] q;
		logic [64:0] r;
		q = '0;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[63:0], num[i]};
			if (r >= {1'b0, den}) begin
				r = r - {1'b0, den};
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic logic signed [63:0] atan_q60(input int idx);
		logic signed [63:0] sum;
		logic signed [63:0] term;
		int e;
		sum = '0;
		if (idx == 0) begin
			sum = PI60 >>> 2;
		end else begin
			for (int k = 0; k < 64; k++) begin
				e = idx * (2 * k + 1);
				if (e <= 60) begin
					term = $signed(udiv64(64'(64'sd1 <<< (60 - e)), 64'(2 * k + 1)));
					sum = ((k & 1) != 0) ? sum - term : sum + term;
				end
			end
		end
		return sum;
	endfunction

	function automatic logic [GINV_W-1:0] gain_inv(input int stages);
		logic signed [63:0] x;
		logic signed [63:0] y;
		logic signed [63:0] xs;
		logic signed [63:0] ys;
		int n;
		x = 64'sd1 <<< 30;
		y = '0;
		n = (stages < 32) ? stages : 32;
		for (int i = 0; i < 32; i++) begin
			if (i < n) begin
				xs = x >>> i;
				ys = y >>> i;
				if (y > 0) begin
					x = x + ys;
					y = y - xs;
				end else begin
					x = x - ys;
					y = y + xs;
				end
			end
		end
		if (x <= 0) begin
			x = 64'sd1;
		end
		return GINV_W'(udiv64(64'(64'sd1 <<< (KBITS + 30)), 64'(x)));
	endfunction

	function automatic logic [63:0] pi_q(input int frac);
		return (PI60 + (64'sd1 <<< (59 - frac))) >>> (60 - frac);
	endfunction

	function automatic logic [63:0] twopi_q(input int frac);
		return (PI60 + (64'sd1 <<< (58 - frac))) >>> (59 - frac);
	endfunction

	function automatic logic [31:0] sat_s32(input logic signed [DW-1:0] v);
		logic [31:0] r;
		if (v > DW'(64'sd2147483647)) begin
			r = 32'h7FFFFFFF;
		end else if (v < -DW'(64'sd2147483648)) begin
			r = 32'h80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

// File: hw/rtl/frd_mod_cell.sv
module frd_mod_cell #(
	parameter int SHIFT = 0,
	parameter int FRAC = 16,
	parameter int SBW = 1
) (
	input  logic clk,
	input  logic en,
	input  logic [31:0] rem_i,
	input  logic [SBW-1:0] sb_i,
	output logic [31:0] rem_o,
	output logic [SBW-1:0] sb_o
);
	import frd_pkg::*;

	localparam logic [33:0] SUB = 34'(twopi_q(FRAC) << SHIFT);

	always_ff @(posedge clk) begin
		if (en) begin
			if ({2'b00, rem_i} >= SUB) begin
				rem_o <= rem_i - SUB[31:0];
			end else begin
				rem_o <= rem_i;
			end
			sb_o <= sb_i;
		end
	end
endmodule

// File: hw/rtl/frd_rot_cell.sv
module frd_rot_cell #(
	parameter int IDX = 0,
	parameter int SBW = 1
) (
	input  logic clk,
	input  logic en,
	input  logic signed [frd_pkg::DW-1:0] x_i,
	input  logic signed [frd_pkg::DW-1:0] y_i,
	input  logic signed [63:0] z_i,
	input  logic [SBW-1:0] sb_i,
	output logic signed [frd_pkg::DW-1:0] x_o,
	output logic signed [frd_pkg::DW-1:0] y_o,
	output logic signed [63:0] z_o,
	output logic [SBW-1:0] sb_o
);
	import frd_pkg::*;

	localparam logic signed [63:0] ATAN = atan_q60(IDX);

	logic signed [DW-1:0] xs;
	logic signed [DW-1:0] ys;

	assign xs = x_i >>> IDX;
	assign ys = y_i >>> IDX;

	always_ff @(posedge clk) begin
		if (en) begin
			if (z_i >= 0) begin
				x_o <= x_i - ys;
				y_o <= y_i + xs;
				z_o <= z_i - ATAN;
			end else begin
				x_o <= x_i + ys;
				y_o <= y_i - xs;
				z_o <= z_i + ATAN;
			end
			sb_o <= sb_i;
		end
	end
endmodule

// File: hw/rtl/frd_vec_cell.sv
module frd_vec_cell #(
	parameter int IDX = 0,
	parameter int SBW = 1
) (
	input  logic clk,
	input  logic en,
	input  logic signed [frd_pkg::DW-1:0] x_i,
	input  logic signed [frd_pkg::DW-1:0] y_i,
	input  logic [SBW-1:0] sb_i,
	output logic signed [frd_pkg::DW-1:0] x_o,
	output logic signed [frd_pkg::DW-1:0] y_o,
	output logic [SBW-1:0] sb_o
);
	import frd_pkg::*;

	logic signed [DW-1:0] xs;
	logic signed [DW-1:0] ys;

	assign xs = x_i >>> IDX;
	assign ys = y_i >>> IDX;

	always_ff @(posedge clk) begin
		if (en) begin
			if (y_i > 0) begin
				x_o <= x_i + ys;
				y_o <= y_i - xs;
			end else begin
				x_o <= x_i - ys;
				y_o <= y_i + xs;
			end
			sb_o <= sb_i;
		end
	end
endmodule

// File: hw/rtl/frd_scale.sv
module frd_scale #(
	parameter int STAGES = 16,
	parameter int LANES = 1,
	parameter int SBW = 1
) (
	input  logic clk,
	input  logic en,
	input  logic signed [frd_pkg::DW-1:0] v_i [LANES],
	input  logic [SBW-1:0] sb_i,
	output logic signed [frd_pkg::DW-1:0] v_o [LANES],
	output logic [SBW-1:0] sb_o
);
	import frd_pkg::*;

	localparam logic [GINV_W-1:0] GINV = gain_inv(STAGES);
	localparam int RSH = KBITS + GUARD;
	localparam int AW = DW + RSH + 4;
	localparam logic signed [AW-1:0] RND = AW'(64'sd1 <<< (RSH - 1));

	logic signed [DW-SPLIT+GINV_W:0] ph_s1 [LANES];
	logic [SPLIT+GINV_W-1:0] pl_s1 [LANES];
	logic [SBW-1:0] sb_s1;
	logic signed [AW-1:0] acc [LANES];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < LANES; l++) begin
				ph_s1[l] <= $signed(v_i[l][DW-1:SPLIT]) * $signed({1'b0, GINV});
				pl_s1[l] <= v_i[l][SPLIT-1:0] * GINV;
			end
			sb_s1 <= sb_i;
		end
	end

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			acc[l] = (AW'(ph_s1[l]) <<< SPLIT) + AW'($signed({1'b0, pl_s1[l]})) + RND;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < LANES; l++) begin
				v_o[l] <= acc[l][RSH+DW-1:RSH];
			end
			sb_o <= sb_s1;
		end
	end
endmodule

// File: hw/rtl/frame_rotate_and_distance.sv
// Throughput: one item per cycle unless stalled; mod-2pi, both CORDIC chains fully pipelined.
// The whole pipeline advances together and holds while a result waits for out_ready.
// Reset: arst_n clears all valid bits; payload registers are not reset.
module frame_rotate_and_distance #(
	parameter int CORDIC_STAGES = 16,
	parameter int FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic signed [31:0] point_heading,
	input  logic signed [31:0] point_frame_angle,
	input  logic signed [31:0] target_frame_angle,
	input  logic signed [31:0] ref_x,
	input  logic signed [31:0] ref_y,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [31:0] rotated_x,
	output logic signed [31:0] rotated_y,
	output logic signed [31:0] rotated_heading,
	output logic [31:0] separation
);
	import frd_pkg::*;

	localparam int S = (CORDIC_STAGES < 32) ? CORDIC_STAGES : 32;
	localparam int R = 31 - FRAC_BITS;
	localparam int NV = 2 * S + R + 8;
	localparam int PSW = $bits(pose_sb_t);
	localparam int DSW = $bits(dist_sb_t);
	localparam logic signed [33:0] PI_F = 34'(pi_q(FRAC_BITS));
	localparam logic signed [33:0] TWOPI_F = 34'(twopi_q(FRAC_BITS));
	localparam logic signed [63:0] HALF = PI60 >>> 1;

	logic en;
	logic [NV-1:0] vld_q;

	assign en = !vld_q[NV-1] || out_ready;
	assign in_ready = en;
	assign out_valid = vld_q[NV-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NV-2:0], in_valid};
		end
	end

	logic signed [32:0] diff;
	pose_sb_t sb_in;
	logic [31:0] rem_s1;
	pose_sb_t sb_s1;

	always_comb begin
		diff = 33'(target_frame_angle) - 33'(point_frame_angle);
		sb_in.hd = 34'(point_heading) - 34'(diff);
		sb_in.px = point_x;
		sb_in.py = point_y;
		sb_in.qx = ref_x;
		sb_in.qy = ref_y;
		sb_in.nz = (diff != '0);
		sb_in.neg = diff[32];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s1 <= diff[32] ? 32'(-diff) : diff[31:0];
			sb_s1 <= sb_in;
		end
	end

	logic [31:0] rem_c [R+1];
	logic [PSW-1:0] msb_c [R+1];

	assign rem_c[0] = rem_s1;
	assign msb_c[0] = sb_s1;

	for (genvar j = 0; j < R; j++) begin : g_mod
		frd_mod_cell #(.SHIFT(R - 1 - j), .FRAC(FRAC_BITS), .SBW(PSW)) u_cell (
			.clk(clk), .en(en),
			.rem_i(rem_c[j]), .sb_i(msb_c[j]),
			.rem_o(rem_c[j+1]), .sb_o(msb_c[j+1])
		);
	end

	pose_sb_t msb;
	logic signed [33:0] r_fold;
	logic signed [33:0] r_red;
	logic signed [63:0] ang;
	logic signed [DW-1:0] x0;
	logic signed [DW-1:0] y0;
	logic signed [DW-1:0] x_s2;
	logic signed [DW-1:0] y_s2;
	logic signed [63:0] z_s2;
	pose_sb_t sb_s2;

	always_comb begin
		msb = pose_sb_t'(msb_c[R]);
		if (msb.neg && rem_c[R] != '0) begin
			r_fold = TWOPI_F - 34'(rem_c[R]);
		end else begin
			r_fold = 34'(rem_c[R]);
		end
		r_red = (r_fold > PI_F) ? r_fold - TWOPI_F : r_fold;
		ang = -(64'(r_red) <<< (60 - FRAC_BITS));
		x0 = DW'(msb.px) <<< GUARD;
		y0 = DW'(msb.py) <<< GUARD;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (ang > HALF) begin
				x_s2 <= -y0;
				y_s2 <= x0;
				z_s2 <= ang - HALF;
			end else if (ang < -HALF) begin
				x_s2 <= y0;
				y_s2 <= -x0;
				z_s2 <= ang + HALF;
			end else begin
				x_s2 <= x0;
				y_s2 <= y0;
				z_s2 <= ang;
			end
			sb_s2 <= msb;
		end
	end

	logic signed [DW-1:0] rx_c [S+1];
	logic signed [DW-1:0] ry_c [S+1];
	logic signed [63:0] rz_c [S+1];
	logic [PSW-1:0] rsb_c [S+1];

	assign rx_c[0] = x_s2;
	assign ry_c[0] = y_s2;
	assign rz_c[0] = z_s2;
	assign rsb_c[0] = sb_s2;

	for (genvar i = 0; i < S; i++) begin : g_rot
		frd_rot_cell #(.IDX(i), .SBW(PSW)) u_cell (
			.clk(clk), .en(en),
			.x_i(rx_c[i]), .y_i(ry_c[i]), .z_i(rz_c[i]), .sb_i(rsb_c[i]),
			.x_o(rx_c[i+1]), .y_o(ry_c[i+1]), .z_o(rz_c[i+1]), .sb_o(rsb_c[i+1])
		);
	end

	logic signed [DW-1:0] rsc_in [2];
	logic signed [DW-1:0] rsc_out [2];
	logic [PSW-1:0] rsc_sb;

	assign rsc_in[0] = rx_c[S];
	assign rsc_in[1] = ry_c[S];

	frd_scale #(.STAGES(S), .LANES(2), .SBW(PSW)) u_rot_scale (
		.clk(clk), .en(en),
		.v_i(rsc_in), .sb_i(rsb_c[S]),
		.v_o(rsc_out), .sb_o(rsc_sb)
	);

	pose_sb_t psb;
	logic signed [DW-1:0] rx;
	logic signed [DW-1:0] ry;
	logic signed [DW:0] dx;
	logic signed [DW:0] dy;
	logic [DW:0] adx;
	logic [DW:0] ady;
	logic signed [DW-1:0] vx_s3;
	logic signed [DW-1:0] vy_s3;
	dist_sb_t dsb;
	dist_sb_t sb_s3;

	always_comb begin
		psb = pose_sb_t'(rsc_sb);
		rx = psb.nz ? rsc_out[0] : DW'(psb.px);
		ry = psb.nz ? rsc_out[1] : DW'(psb.py);
		dx = (DW+1)'(rx) - (DW+1)'(psb.qx);
		dy = (DW+1)'(ry) - (DW+1)'(psb.qy);
		adx = dx[DW] ? (DW+1)'(-dx) : dx;
		ady = dy[DW] ? (DW+1)'(-dy) : dy;
		dsb.rx = sat_s32(rx);
		dsb.ry = sat_s32(ry);
		dsb.hd = sat_s32(DW'(psb.hd));
		dsb.far = (adx[DW:32] != '0) || (ady[DW:32] != '0);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vx_s3 <= $signed({adx[DW-1-GUARD:0], GUARD'(0)});
			vy_s3 <= $signed({ady[DW-1-GUARD:0], GUARD'(0)});
			sb_s3 <= dsb;
		end
	end

	logic signed [DW-1:0] vx_c [S+1];
	logic signed [DW-1:0] vy_c [S+1];
	logic [DSW-1:0] vsb_c [S+1];

	assign vx_c[0] = vx_s3;
	assign vy_c[0] = vy_s3;
	assign vsb_c[0] = sb_s3;

	for (genvar i = 0; i < S; i++) begin : g_vec
		frd_vec_cell #(.IDX(i), .SBW(DSW)) u_cell (
			.clk(clk), .en(en),
			.x_i(vx_c[i]), .y_i(vy_c[i]), .sb_i(vsb_c[i]),
			.x_o(vx_c[i+1]), .y_o(vy_c[i+1]), .sb_o(vsb_c[i+1])
		);
	end

	logic signed [DW-1:0] msc_in [1];
	logic signed [DW-1:0] msc_out [1];
	logic [DSW-1:0] msc_sb;
	dist_sb_t fsb;

	assign msc_in[0] = vx_c[S];

	frd_scale #(.STAGES(S), .LANES(1), .SBW(DSW)) u_mag_scale (
		.clk(clk), .en(en),
		.v_i(msc_in), .sb_i(vsb_c[S]),
		.v_o(msc_out), .sb_o(msc_sb)
	);

	assign fsb = dist_sb_t'(msc_sb);

	always_ff @(posedge clk) begin
		if (en) begin
			rotated_x <= fsb.rx;
			rotated_y <= fsb.ry;
			rotated_heading <= fsb.hd;
			if (fsb.far || msc_out[0][DW-2:32] != '0 && !msc_out[0][DW-1]) begin
				separation <= 32'hFFFFFFFF;
			end else if (msc_out[0][DW-1]) begin
				separation <= '0;
			end else begin
				separation <= msc_out[0][31:0];
			end
		end
	end

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while result stalled");

	a_transfer_enters: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> vld_q[0])
		else $error("accepted item lost at pipeline entry");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |=> $stable(vld_q))
		else $error("pipeline moved while stalled");

endmodule
